// ===== rtl/core/vpls_pkg.sv =====
// ----------------------------------------------------------------------------
// vpls_pkg
// Types and constants shared by the vertex point-light shader: request and
// result payloads, light positions, controller states and unit status.
// ----------------------------------------------------------------------------
package vpls_pkg;

	// Field widths
	localparam int COORD_W  = 16;
	localparam int SLOT_W   = 3;
	localparam int COLOR_W  = 8;
	localparam int RADIUS_W = 12;
	localparam int BOOST_W  = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BOOST    = 2'd1;

	// Reset values of the registers
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd1200;
	localparam logic [BOOST_W-1:0]  BOOST_RESET  = 8'd100;

	// Request modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_SHADE = 1'b1;

	// Shading constants
	localparam int INNER_RADIUS = 10;
	localparam logic [COLOR_W-1:0] CHANNEL_MAX = 8'd255;

	// Square root unit: radicand below 2^25, padded to an even width
	localparam int RAD_W          = 28;
	localparam int ROOT_W         = RAD_W / 2;
	localparam int ROOT_REM_W     = ROOT_W + 3;
	localparam int ROOT_PER_CYCLE = 2;
	localparam int ROOT_CYCLES    = ROOT_W / ROOT_PER_CYCLE;

	// Divider unit: boost * (radius - d) / (radius - inner), quotient of 8 bits
	localparam int DIVIDEND_W    = BOOST_W + RADIUS_W;
	localparam int QUOT_W        = BOOST_W;
	localparam int DIV_PER_CYCLE = 4;
	localparam int DIV_CYCLES    = QUOT_W / DIV_PER_CYCLE;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic                      mode;
		logic [SLOT_W-1:0]         slot;
		logic                      light_on;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [COLOR_W-1:0]        hi_red;
		logic [COLOR_W-1:0]        hi_green;
		logic [COLOR_W-1:0]        hi_blue;
		logic [COLOR_W-1:0]        lo_red;
		logic [COLOR_W-1:0]        lo_green;
		logic [COLOR_W-1:0]        lo_blue;
	} in_item_t;

	typedef struct packed {
		logic [BOOST_W-1:0] boost;
		logic [COLOR_W-1:0] out_hi_red;
		logic [COLOR_W-1:0] out_hi_green;
		logic [COLOR_W-1:0] out_hi_blue;
		logic [COLOR_W-1:0] out_lo_red;
		logic [COLOR_W-1:0] out_lo_green;
		logic [COLOR_W-1:0] out_lo_blue;
	} out_item_t;

	// Status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_TEST,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_SCALE,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/vpls_if.sv =====
// ----------------------------------------------------------------------------
// vpls channel interfaces
// Valid/ready channels for shade and load requests, shaded results and
// configuration writes.
// ----------------------------------------------------------------------------
interface vpls_in_if;
	import vpls_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface vpls_out_if;
	import vpls_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface vpls_cfg_if;
	import vpls_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/vpls_light_mem.sv =====
// ----------------------------------------------------------------------------
// vpls_light_mem
// Light table: positions in a synchronous memory with registered read,
// enable bits in flops that reset clears, so unwritten slots read as off.
// ----------------------------------------------------------------------------
module vpls_light_mem #(
	parameter int LIGHTS = 8,
	parameter int IDX_W  = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic             wr_on,
	input  vpls_pkg::pos_t   wr_pos,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic             rd_on,
	output vpls_pkg::pos_t   rd_pos
);
	import vpls_pkg::*;

	pos_t         pos_mem_q [LIGHTS];
	logic [LIGHTS-1:0] on_q;
	logic         rd_on_q;
	pos_t         rd_pos_q;

	// Write positions
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem_q[wr_idx] <= wr_pos;
		end
	end

	// Write enable bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q <= '0;
		end else if (wr_en) begin
			on_q[wr_idx] <= wr_on;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pos_q <= pos_mem_q[rd_idx];
			rd_on_q  <= on_q[rd_idx];
		end
	end

	assign rd_on  = rd_on_q;
	assign rd_pos = rd_pos_q;

endmodule

// ===== rtl/core/vpls_root.sv =====
// ----------------------------------------------------------------------------
// vpls_root
// Floor square root, digit by digit, two result bits per cycle.
// ----------------------------------------------------------------------------
module vpls_root (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [vpls_pkg::RAD_W-1:0] radicand,
	output vpls_pkg::unit_stat_t       stat,
	output logic [vpls_pkg::ROOT_W-1:0] root
);
	import vpls_pkg::*;

	localparam int CNT_W = (ROOT_CYCLES > 1) ? $clog2(ROOT_CYCLES) : 1;

	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_REM_W-1:0] rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [RAD_W-1:0]      rad_n;
	logic [ROOT_REM_W-1:0] rem_n;
	logic [ROOT_W-1:0]     root_n;
	logic [ROOT_REM_W-1:0] trial;

	// Run the steps of one cycle
	always_comb begin
		rad_n  = rad_q;
		rem_n  = rem_q;
		root_n = root_q;
		trial  = '0;
		for (int s = 0; s < ROOT_PER_CYCLE; s++) begin
			rem_n = {rem_n[ROOT_REM_W-3:0], rad_n[RAD_W-1 -: 2]};
			rad_n = {rad_n[RAD_W-3:0], 2'b00};
			trial = ROOT_REM_W'({root_n, 2'b01});
			if (rem_n >= trial) begin
				rem_n  = rem_n - trial;
				root_n = {root_n[ROOT_W-2:0], 1'b1};
			end else begin
				root_n = {root_n[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_n;
			rem_q  <= rem_n;
			root_q <= root_n;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

// ===== rtl/core/vpls_div.sv =====
// ----------------------------------------------------------------------------
// vpls_div
// Falloff scaler: registers boost * span, then divides it by the falloff
// width with a restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module vpls_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vpls_pkg::BOOST_W-1:0]  boost,
	input  logic [vpls_pkg::RADIUS_W-1:0] span,
	input  logic [vpls_pkg::RADIUS_W-1:0] width,
	output vpls_pkg::unit_stat_t          stat,
	output logic [vpls_pkg::QUOT_W-1:0]   quot
);
	import vpls_pkg::*;

	localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int DSH_W = RADIUS_W + QUOT_W - 1;

	logic [DIVIDEND_W-1:0] rem_q;
	logic [DSH_W-1:0]      dsh_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVIDEND_W-1:0] rem_n;
	logic [DSH_W-1:0]      dsh_n;
	logic [QUOT_W-1:0]     quot_n;

	// Run the steps of one cycle
	always_comb begin
		rem_n  = rem_q;
		dsh_n  = dsh_q;
		quot_n = quot_q;
		for (int s = 0; s < DIV_PER_CYCLE; s++) begin
			if (rem_n >= DIVIDEND_W'(dsh_n)) begin
				rem_n  = rem_n - DIVIDEND_W'(dsh_n);
				quot_n = {quot_n[QUOT_W-2:0], 1'b1};
			end else begin
				quot_n = {quot_n[QUOT_W-2:0], 1'b0};
			end
			dsh_n = dsh_n >> 1;
		end
	end

	// Datapath: product on start, then quotient steps
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DIVIDEND_W'(boost * span);
			dsh_q  <= {width, (QUOT_W - 1)'(0)};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			dsh_q  <= dsh_n;
			quot_q <= quot_n;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

// ===== rtl/core/vertex_point_light_shader_unit.sv =====
// ----------------------------------------------------------------------------
// vertex_point_light_shader_unit
// Vertex lighting from a table of point lights: strongest light in reach
// brightens both vertex colors.
// ----------------------------------------------------------------------------
// A load request (mode 0) writes the enable bit and position of one light slot
// and gives no result; slots at or past LIGHTS are ignored. A shade request
// (mode 1) walks the light table one slot at a time, reading each entry from
// the light memory: a slot that is off or whose cube of half-width
// light_radius misses the vertex is skipped after the box test; a hit is
// squared, summed and put through the square root unit (two root bits a
// cycle); one inside the inner radius gets the full boost, one past the
// radius none, and one in the falloff zone goes through the falloff divider
// (four quotient bits a cycle). The result waits in an output register, so
// the next request is taken while it is still pending. Configuration writes
// are taken at any time but belong between requests.
// ----------------------------------------------------------------------------
module vertex_point_light_shader_unit #(
	parameter int LIGHTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	vpls_in_if.sink    items,
	vpls_out_if.source results,
	vpls_cfg_if.sink   cfg
);
	import vpls_pkg::*;

	localparam int IDX_W = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;

	state_t state_q;
	state_t state_d;

	logic [RADIUS_W-1:0]   light_radius_q;
	logic [BOOST_W-1:0]    max_boost_q;
	in_item_t              item_q;
	logic [IDX_W-1:0]      light_q;
	logic [BOOST_W-1:0]    best_q;
	logic [RADIUS_W-1:0]   ax_q;
	logic [RADIUS_W-1:0]   az_q;
	logic [2*RADIUS_W-1:0] sq_x_q;
	logic [2*RADIUS_W-1:0] sq_z_q;
	out_item_t             out_q;
	logic                  out_valid_q;

	logic                  in_accept;
	logic                  slot_ok;
	logic                  load_wr;
	logic                  rd_en;
	logic                  rd_on;
	pos_t                  rd_pos;
	logic                  hit;
	logic                  light_last;
	logic                  advance;
	logic                  root_start;
	logic                  div_start;
	logic                  out_load;
	logic                  reach;
	logic                  full;
	logic [RAD_W-1:0]      radicand;
	logic [ROOT_W-1:0]     root;
	logic [QUOT_W-1:0]     quot;
	unit_stat_t            root_stat;
	unit_stat_t            div_stat;
	pos_t                  wr_pos;

	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic signed [COORD_W:0] dz;
	logic signed [COORD_W:0] r_pos;
	logic signed [COORD_W:0] r_neg;
	logic signed [COORD_W:0] ax_full;
	logic signed [COORD_W:0] az_full;

	function automatic logic [COLOR_W-1:0] sat_add(input logic [COLOR_W-1:0] c,
			input logic [BOOST_W-1:0] b);
		logic [COLOR_W:0] s;
		s = {1'b0, c} + (COLOR_W + 1)'(b);
		return s[COLOR_W] ? CHANNEL_MAX : s[COLOR_W-1:0];
	endfunction

	// Request handshake and load writes
	assign in_accept = items.valid && items.ready;
	assign slot_ok   = 32'(items.payload.slot) < LIGHTS;
	assign load_wr   = in_accept && (items.payload.mode == MODE_LOAD) && slot_ok;
	assign wr_pos    = '{x: items.payload.pos_x, y: items.payload.pos_y,
	                     z: items.payload.pos_z};

	vpls_light_mem #(
		.LIGHTS (LIGHTS),
		.IDX_W  (IDX_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (load_wr),
		.wr_idx (IDX_W'(items.payload.slot)),
		.wr_on  (items.payload.light_on),
		.wr_pos (wr_pos),
		.rd_en  (rd_en),
		.rd_idx (light_q),
		.rd_on  (rd_on),
		.rd_pos (rd_pos)
	);

	// Box test against the light just read
	always_comb begin
		dx      = {item_q.pos_x[COORD_W-1], item_q.pos_x} - {rd_pos.x[COORD_W-1], rd_pos.x};
		dy      = {item_q.pos_y[COORD_W-1], item_q.pos_y} - {rd_pos.y[COORD_W-1], rd_pos.y};
		dz      = {item_q.pos_z[COORD_W-1], item_q.pos_z} - {rd_pos.z[COORD_W-1], rd_pos.z};
		r_pos   = {(COORD_W + 1 - RADIUS_W)'(0), light_radius_q};
		r_neg   = -r_pos;
		ax_full = dx[COORD_W] ? -dx : dx;
		az_full = dz[COORD_W] ? -dz : dz;
		hit     = rd_on
		          && (dx >= r_neg) && (dx <= r_pos)
		          && (dy >= r_neg) && (dy <= r_pos)
		          && (dz >= r_neg) && (dz <= r_pos);
	end

	// Distance to brightness
	assign radicand   = RAD_W'({1'b0, sq_x_q} + {1'b0, sq_z_q});
	assign reach      = root < ROOT_W'(light_radius_q);
	assign full       = root < ROOT_W'(INNER_RADIUS);
	assign light_last = light_q == IDX_W'(LIGHTS - 1);

	vpls_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.stat     (root_stat),
		.root     (root)
	);

	vpls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.boost  (max_boost_q),
		.span   (light_radius_q - root[RADIUS_W-1:0]),
		.width  (light_radius_q - RADIUS_W'(INNER_RADIUS)),
		.stat   (div_stat),
		.quot   (quot)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && (items.payload.mode == MODE_SHADE)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_TEST;
			end
			ST_TEST: begin
				if (hit) begin
					state_d = ST_SQUARE;
				end else begin
					state_d = light_last ? ST_DONE : ST_READ;
				end
			end
			ST_SQUARE: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_stat.done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (!reach || full) begin
					state_d = light_last ? ST_DONE : ST_READ;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = light_last ? ST_DONE : ST_READ;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || results.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs
	always_comb begin
		items.ready = 1'b0;
		rd_en       = 1'b0;
		root_start  = 1'b0;
		div_start   = 1'b0;
		advance     = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				items.ready = 1'b1;
			end
			ST_READ: begin
				rd_en = 1'b1;
			end
			ST_TEST: begin
				advance = !hit;
			end
			ST_SUM: begin
				root_start = 1'b1;
			end
			ST_SCALE: begin
				advance   = !reach || full;
				div_start = reach && !full;
			end
			ST_DIV: begin
				advance = div_stat.done;
			end
			ST_DONE: begin
				out_load = !out_valid_q || results.ready;
			end
			default: begin
				items.ready = 1'b0;
			end
		endcase
	end

	// State register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			light_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				light_q <= '0;
			end else if (advance && !light_last) begin
				light_q <= light_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_radius_q <= RADIUS_RESET;
			max_boost_q    <= BOOST_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_LIGHT_RADIUS: light_radius_q <= cfg.data[RADIUS_W-1:0];
				REG_MAX_BOOST:    max_boost_q    <= cfg.data[BOOST_W-1:0];
				default:          ;
			endcase
		end
	end

	// Shading datapath: hold request, track strongest light
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q <= items.payload;
			best_q <= '0;
		end else if ((state_q == ST_SCALE) && reach && full && (max_boost_q > best_q)) begin
			best_q <= max_boost_q;
		end else if ((state_q == ST_DIV) && div_stat.done && (quot > best_q)) begin
			best_q <= quot;
		end
		if (state_q == ST_TEST) begin
			ax_q <= ax_full[RADIUS_W-1:0];
			az_q <= az_full[RADIUS_W-1:0];
		end
		if (state_q == ST_SQUARE) begin
			sq_x_q <= ax_q * ax_q;
			sq_z_q <= az_q * az_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.boost        <= best_q;
			out_q.out_hi_red   <= sat_add(item_q.hi_red, best_q);
			out_q.out_hi_green <= sat_add(item_q.hi_green, best_q);
			out_q.out_hi_blue  <= sat_add(item_q.hi_blue, best_q);
			out_q.out_lo_red   <= sat_add(item_q.lo_red, best_q);
			out_q.out_lo_green <= sat_add(item_q.lo_green, best_q);
			out_q.out_lo_blue  <= sat_add(item_q.lo_blue, best_q);
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

`ifndef SYNTHESIS
	// The root unit runs only while the controller waits for it
	a_root_owned: assert property (@(posedge clk) disable iff (!arst_n)
		root_stat.busy |-> (state_q == ST_ROOT))
		else $error("square root unit busy outside its wait state");

	// The divider runs only while the controller waits for it
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside its wait state");

	// A shade request blocks further requests until its result is loaded
	a_shade_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (items.payload.mode == MODE_SHADE)) |=> !items.ready)
		else $error("request accepted while a shade is in progress");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: vertex point-light shader unit
// Drives load and shade requests through the valid/ready channels, lights
// each shaded vertex again from a local copy of the light table and the
// registers, and compares every returned color set field by field.
// Directed cases come first, then random phases over several radius and
// brightness settings.
// ----------------------------------------------------------------------------
module tb;
	import vpls_pkg::*;

	localparam int LIGHTS        = 8;
	localparam int SETTLE_CYCLES = 2 + 16 * LIGHTS + 20;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 125;

	typedef enum {PACE_FREE, PACE_RANDOM, PACE_RUNS} pace_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	vpls_in_if  req_if ();
	vpls_out_if res_if ();
	vpls_cfg_if cfg_if ();

	vertex_point_light_shader_unit #(
		.LIGHTS(LIGHTS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (req_if),
		.results(res_if),
		.cfg    (cfg_if)
	);

	// Local copy of the light table and registers
	logic                lamp_on [LIGHTS] = '{default: 1'b0};
	pos_t                lamp_pos[LIGHTS] = '{default: '0};
	logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;
	logic [BOOST_W-1:0]  boost_reg  = BOOST_RESET;

	out_item_t lit_colors_q[$];
	int        mismatch_count = 0;
	int        quiet_cycles   = 0;
	int        burst_left     = 0;
	bit        steady_sender  = 1'b0;
	pace_t     pace_style     = PACE_FREE;
	int        pace_count     = 0;
	int        run_left       = 0;
	bit        run_high       = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic int floor_root(longint v);
		longint root;
		longint trial;
		root = 0;
		for (int k = 15; k >= 0; k--) begin
			trial = root + (longint'(1) << k);
			if (trial * trial <= v)
				root = trial;
		end
		return int'(root);
	endfunction

	function automatic logic [COLOR_W-1:0] add_sat(logic [COLOR_W-1:0] c, int b);
		int s;
		s = int'(c) + b;
		return (s > int'(CHANNEL_MAX)) ? CHANNEL_MAX : s[COLOR_W-1:0];
	endfunction

	function automatic void store_light(in_item_t it);
		if (int'(it.slot) < LIGHTS) begin
			lamp_on[it.slot]    = it.light_on;
			lamp_pos[it.slot].x = it.pos_x;
			lamp_pos[it.slot].y = it.pos_y;
			lamp_pos[it.slot].z = it.pos_z;
		end
	endfunction

	function automatic out_item_t light_vertex(in_item_t it);
		int        r, dx, dy, dz, d, b, best;
		longint    dist_sq;
		out_item_t o;
		r    = int'(radius_reg);
		best = 0;
		for (int i = 0; i < LIGHTS; i++) begin
			if (!lamp_on[i])
				continue;
			dx = int'($signed(it.pos_x)) - int'($signed(lamp_pos[i].x));
			dy = int'($signed(it.pos_y)) - int'($signed(lamp_pos[i].y));
			dz = int'($signed(it.pos_z)) - int'($signed(lamp_pos[i].z));
			// skip lights whose cube misses the vertex
			if (dx < -r || dx > r || dy < -r || dy > r || dz < -r || dz > r)
				continue;
			dist_sq = longint'(dx) * dx + longint'(dz) * dz;
			d = floor_root(dist_sq);
			if (d >= r)
				continue;
			if (d < INNER_RADIUS)
				b = int'(boost_reg);
			else
				b = int'(boost_reg) * (r - d) / (r - INNER_RADIUS);
			if (b > best)
				best = b;
		end
		o.boost        = best[BOOST_W-1:0];
		o.out_hi_red   = add_sat(it.hi_red, best);
		o.out_hi_green = add_sat(it.hi_green, best);
		o.out_hi_blue  = add_sat(it.hi_blue, best);
		o.out_lo_red   = add_sat(it.lo_red, best);
		o.out_lo_green = add_sat(it.lo_green, best);
		o.out_lo_blue  = add_sat(it.lo_blue, best);
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_channel(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// Track config writes and requests, check results, watch for a hang
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_LIGHT_RADIUS: radius_reg = cfg_if.data[RADIUS_W-1:0];
					REG_MAX_BOOST:    boost_reg  = cfg_if.data[BOOST_W-1:0];
					default: ;
				endcase
			end
			if (req_if.valid && req_if.ready) begin
				if (req_if.payload.mode == MODE_SHADE)
					lit_colors_q.push_back(light_vertex(req_if.payload));
				else
					store_light(req_if.payload);
			end
			if (res_if.valid && res_if.ready) begin
				if (lit_colors_q.size() == 0) begin
					report_mismatch("result with no shade request pending");
				end else begin
					want = lit_colors_q.pop_front();
					check_channel("boost", res_if.payload.boost, want.boost);
					check_channel("out_hi_red", res_if.payload.out_hi_red, want.out_hi_red);
					check_channel("out_hi_green", res_if.payload.out_hi_green,
						want.out_hi_green);
					check_channel("out_hi_blue", res_if.payload.out_hi_blue, want.out_hi_blue);
					check_channel("out_lo_red", res_if.payload.out_lo_red, want.out_lo_red);
					check_channel("out_lo_green", res_if.payload.out_lo_green,
						want.out_lo_green);
					check_channel("out_lo_blue", res_if.payload.out_lo_blue, want.out_lo_blue);
				end
			end
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("ERROR @%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result side: stall on a changing pattern
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (pace_count == 0) begin
			pace_style = pace_t'($urandom_range(0, 2));
			pace_count = 300;
		end
		pace_count--;
		case (pace_style)
			PACE_FREE:   res_if.ready <= 1'b1;
			PACE_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (run_left == 0) begin
					run_high = !run_high;
					run_left = $urandom_range(1, 20);
				end
				run_left--;
				res_if.ready <= run_high;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [COLOR_W-1:0] rand_color();
		if ($urandom_range(0, 3) == 0)
			return COLOR_W'($urandom_range(200, 255));
		return COLOR_W'($urandom);
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int pick_center();
		case ($urandom_range(0, 9))
			0:       return 32767 - int'($urandom_range(0, 300));
			1:       return -32768 + int'($urandom_range(0, 300));
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic void fill_colors(ref in_item_t it);
		it.hi_red   = rand_color();
		it.hi_green = rand_color();
		it.hi_blue  = rand_color();
		it.lo_red   = rand_color();
		it.lo_green = rand_color();
		it.lo_blue  = rand_color();
	endfunction

	// Colors of a load request carry random junk
	function automatic in_item_t load_item(int s, bit on, int x, int y, int z);
		in_item_t it;
		it.mode     = MODE_LOAD;
		it.slot     = s[SLOT_W-1:0];
		it.light_on = on;
		it.pos_x    = clamp_coord(x);
		it.pos_y    = clamp_coord(y);
		it.pos_z    = clamp_coord(z);
		fill_colors(it);
		return it;
	endfunction

	// Slot and enable of a shade request carry random junk
	function automatic in_item_t shade_item(int x, int y, int z);
		in_item_t it;
		it.mode     = MODE_SHADE;
		it.slot     = SLOT_W'($urandom);
		it.light_on = 1'($urandom);
		it.pos_x    = clamp_coord(x);
		it.pos_y    = clamp_coord(y);
		it.pos_z    = clamp_coord(z);
		fill_colors(it);
		return it;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it.mode     = 1'($urandom);
		it.slot     = SLOT_W'($urandom);
		it.light_on = 1'($urandom);
		it.pos_x    = COORD_W'($urandom);
		it.pos_y    = COORD_W'($urandom);
		it.pos_z    = COORD_W'($urandom);
		fill_colors(it);
		return it;
	endfunction

	// Send one request, in bursts with random gaps between them
	task automatic send_request(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = steady_sender ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_if.valid   <= 1'b1;
		req_if.payload <= it;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
	endtask

	// Drop the request valid and wait until the unit has gone idle
	task automatic settle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		burst_left = 0;
		while (lit_colors_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_dark_table();
		send_request(shade_item(0, 0, 0));
	endtask

	task automatic test_single_light_falloff();
		in_item_t it;
		send_request(load_item(0, 1'b1, 0, 0, 0));
		// inner radius, with channels that saturate and some that do not
		it = shade_item(3, 0, 4);
		it.hi_red   = 8'd255;
		it.hi_green = 8'd200;
		it.hi_blue  = 8'd0;
		it.lo_red   = 8'd156;
		it.lo_green = 8'd155;
		it.lo_blue  = 8'd1;
		send_request(it);
		// inner radius edge, falloff, last step inside and the outer edge
		send_request(shade_item(10, 0, 0));
		send_request(shade_item(600, 0, -5));
		send_request(shade_item(1199, 0, 0));
		send_request(shade_item(1200, 0, 0));
		// cube edges on the vertical axis, and a diagonal just past the radius
		send_request(shade_item(0, 1200, 0));
		send_request(shade_item(0, -1201, 0));
		send_request(shade_item(849, 0, 849));
	endtask

	task automatic test_strongest_light();
		send_request(load_item(7, 1'b1, 500, 0, 0));
		send_request(shade_item(400, 0, 0));
		send_request(load_item(7, 1'b0, 450, 10, -10));
		send_request(shade_item(400, 0, 0));
	endtask

	task automatic test_coordinate_extremes();
		send_request(load_item(3, 1'b1, 32767, 32767, 32767));
		send_request(load_item(4, 1'b1, -32768, -32768, -32768));
		send_request(shade_item(-32768, -32768, -32768));
		send_request(shade_item(32767, 32767, -32768));
		send_request(shade_item(32767, 32767, 32767));
	endtask

	task automatic test_radius_limits();
		write_register(REG_MAX_BOOST, 12'd255);
		write_register(REG_LIGHT_RADIUS, 12'd10);
		send_request(shade_item(9, 0, 0));
		send_request(shade_item(10, 0, 0));
		write_register(REG_LIGHT_RADIUS, 12'd0);
		send_request(shade_item(0, 0, 0));
		write_register(REG_LIGHT_RADIUS, 12'd11);
		send_request(shade_item(10, 0, 0));
		write_register(REG_LIGHT_RADIUS, 12'd4095);
		send_request(shade_item(4095, 4095, 0));
		send_request(shade_item(2895, -4095, 2895));
		send_request(shade_item(-4095, 0, 0));
	endtask

	// Lights around two clusters, vertices mostly near them, some noise
	task automatic test_random_mix(input int n_items, input logic [RADIUS_W-1:0] radius,
			input logic [BOOST_W-1:0] boost, input bit steady);
		int cx[2], cy[2], cz[2];
		int lamp_span, vert_span, c, pick;
		write_register(REG_LIGHT_RADIUS, radius);
		write_register(REG_MAX_BOOST, {4'($urandom_range(0, 15)), boost});
		steady_sender = steady;
		lamp_span = int'(radius) / 2 + 8;
		vert_span = int'(radius) + int'(radius) / 4 + 16;
		for (int k = 0; k < 2; k++) begin
			cx[k] = pick_center();
			cy[k] = pick_center();
			cz[k] = pick_center();
		end
		for (int s = 0; s < LIGHTS; s++) begin
			c = s % 2;
			send_request(load_item(s, $urandom_range(0, 4) != 0, cx[c] + jitter(lamp_span),
				cy[c] + jitter(lamp_span), cz[c] + jitter(lamp_span)));
		end
		for (int n = LIGHTS; n < n_items; n++) begin
			pick = $urandom_range(0, 99);
			c    = $urandom_range(0, 1);
			if (pick < 10)
				send_request(noise_item());
			else if (pick < 22)
				send_request(load_item($urandom_range(0, LIGHTS - 1),
					$urandom_range(0, 4) != 0, cx[c] + jitter(lamp_span),
					cy[c] + jitter(lamp_span), cz[c] + jitter(lamp_span)));
			else
				send_request(shade_item(cx[c] + jitter(vert_span),
					cy[c] + jitter(vert_span), cz[c] + jitter(vert_span)));
		end
	endtask

	task automatic test_random_phases();
		test_random_mix(PHASE_ITEMS, RADIUS_RESET, BOOST_RESET, 1'b0);
		test_random_mix(PHASE_ITEMS, 12'd4095, 8'd255, 1'b1);
		test_random_mix(PHASE_ITEMS, 12'd11, 8'd255, 1'b0);
		test_random_mix(PHASE_ITEMS, 12'd10, 8'd77, 1'b0);
		test_random_mix(PHASE_ITEMS, 12'd0, 8'd200, 1'b1);
		test_random_mix(PHASE_ITEMS, RADIUS_W'($urandom_range(11, 4095)),
			BOOST_W'($urandom), 1'b0);
		test_random_mix(PHASE_ITEMS, 12'd64, 8'd0, 1'b0);
		test_random_mix(PHASE_ITEMS, RADIUS_W'($urandom_range(11, 300)),
			BOOST_W'($urandom), 1'b1);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		cfg_if.valid   = 1'b0;
		cfg_if.index   = REG_LIGHT_RADIUS;
		cfg_if.data    = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_dark_table();
		test_single_light_falloff();
		test_strongest_light();
		test_coordinate_extremes();
		test_radius_limits();
		test_random_phases();

		settle();
		if (mismatch_count == 0 && lit_colors_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
